// File: hdl/lru_pft_pkg.sv
`timescale 1ns / 1ps

package lru_pft_pkg;

  // Frame count and stored page width.
  localparam int NUM_FRAMES = 4;
  localparam int PAGE_BITS  = 16;

  // Derived widths for frame indexes and recency ranks.
  localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int RANK_W  = FRAME_W;

  // Port field widths.
  localparam int PAGE_PORT_W  = 16;
  localparam int INDEX_PORT_W = 2;
  localparam int COUNT_W      = 16;

  localparam logic [COUNT_W-1:0] FAULT_MAX = {COUNT_W{1'b1}};

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [COUNT_W-1:0]   count_t;

endpackage

// File: hdl/lru_page_frame_tracker.sv
`timescale 1ns / 1ps

// Fully associative LRU page frame tracker. A reference is taken whenever start is
// high (busy stays low, so one reference can be issued every cycle), and its result
// appears on the result ports with done high for exactly one cycle after it passes
// the input and result registers. The receiver cannot stall the block. The rate of
// one reference per cycle is set by the lookup stage, which compares the page with all
// frames, picks the frame and updates the recency order combinationally between the
// input and result registers. A reference with last_ref set reports with the updated
// values and then returns every frame, rank and the fault count to empty.
module lru_page_frame_tracker
  import lru_pft_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [PAGE_PORT_W-1:0]  page,
  input  logic                    last_ref,
  output logic                    done,
  output logic                    hit,
  output logic [INDEX_PORT_W-1:0] frame_index,
  output logic                    evicted_valid,
  output logic [PAGE_PORT_W-1:0]  evicted_page,
  output logic [COUNT_W-1:0]      fault_count,
  output logic                    sequence_end
);

  // Input register.
  logic  in_valid;
  page_t in_page;
  logic  in_last;

  // Tracker state.
  page_t                 frame_page [NUM_FRAMES];
  rank_t                 frame_rank [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid;
  count_t                fault_total;

  // Lookup results and next state.
  page_t                 frame_page_next [NUM_FRAMES];
  rank_t                 frame_rank_next [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid_next;
  count_t                fault_total_next;
  logic                  hit_c;
  logic                  evict_c;
  logic                  empty_found;
  frame_t                hit_slot;
  frame_t                empty_slot;
  frame_t                victim;
  frame_t                slot;
  rank_t                 hit_rank;
  rank_t                 old_rank;
  page_t                 victim_page;
  logic                  was_valid;

  // The block never refuses a reference.
  assign busy = 1'b0;

  // Capture each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
    in_page <= PAGE_BITS'(page);
    in_last <= last_ref;
  end

  // Compare with every frame, choose the frame and age the recency order.
  always_comb begin
    hit_c       = 1'b0;
    hit_slot    = '0;
    hit_rank    = '0;
    empty_found = 1'b0;
    empty_slot  = '0;
    victim      = '0;
    victim_page = '0;
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (!hit_c && frame_valid[k] && frame_page[k] == in_page) begin
        hit_c    = 1'b1;
        hit_slot = FRAME_W'(k);
        hit_rank = frame_rank[k];
      end
    end
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (!empty_found && !frame_valid[k]) begin
        empty_found = 1'b1;
        empty_slot  = FRAME_W'(k);
      end
    end
    // When every frame is valid the ranks are distinct, so the oldest is unique.
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (frame_rank[k] == RANK_W'(NUM_FRAMES - 1)) begin
        victim      = FRAME_W'(k);
        victim_page = frame_page[k];
      end
    end
    evict_c   = !hit_c && !empty_found;
    slot      = hit_c ? hit_slot : (empty_found ? empty_slot : victim);
    was_valid = hit_c || evict_c;
    old_rank  = hit_c ? hit_rank : RANK_W'(NUM_FRAMES - 1);

    for (int k = 0; k < NUM_FRAMES; k++) begin
      frame_page_next[k]  = frame_page[k];
      frame_rank_next[k]  = frame_rank[k];
      frame_valid_next[k] = frame_valid[k];
      if (FRAME_W'(k) == slot) begin
        frame_rank_next[k]  = '0;
        frame_valid_next[k] = 1'b1;
        if (!hit_c) begin
          frame_page_next[k] = in_page;
        end
      end else if (frame_valid[k] && (!was_valid || frame_rank[k] < old_rank)) begin
        frame_rank_next[k] = frame_rank[k] + RANK_W'(1);
      end
    end

    if (!hit_c && fault_total != FAULT_MAX) begin
      fault_total_next = fault_total + COUNT_W'(1);
    end else begin
      fault_total_next = fault_total;
    end
  end

  // State update; the final reference of a sequence empties the tracker.
  always_ff @(posedge clk) begin
    if (rst || (in_valid && in_last)) begin
      frame_valid <= '0;
      fault_total <= '0;
      for (int k = 0; k < NUM_FRAMES; k++) begin
        frame_page[k] <= '0;
        frame_rank[k] <= '0;
      end
    end else if (in_valid) begin
      frame_valid <= frame_valid_next;
      fault_total <= fault_total_next;
      for (int k = 0; k < NUM_FRAMES; k++) begin
        frame_page[k] <= frame_page_next[k];
        frame_rank[k] <= frame_rank_next[k];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    hit           <= hit_c;
    frame_index   <= INDEX_PORT_W'(slot);
    evicted_valid <= evict_c;
    evicted_page  <= evict_c ? PAGE_PORT_W'(victim_page) : '0;
    fault_count   <= fault_total_next;
    sequence_end  <= in_last;
  end

  // A transfer always reaches the lookup stage in the next cycle.
  a_start_to_lookup: assert property (@(posedge clk) disable iff (rst)
    start |=> in_valid)
    else $error("accepted reference did not reach the lookup stage");

  // An eviction is only reported for a miss.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> !hit)
    else $error("eviction reported on a hit");

  // A reported miss always leaves a nonzero fault count.
  a_miss_counts: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> fault_count != '0)
    else $error("miss reported with a zero fault count");

  // The last reference of a sequence empties every frame.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_last) |=> (frame_valid == '0 && fault_total == '0))
    else $error("tracker not emptied after end of sequence");

endmodule

// File: dv/lru_frame_checker.sv
`timescale 1ns / 1ps

// Watches the reference and result channels of the LRU page frame tracker,
// keeps its own copy of the frame table and reports every result that does
// not match the predicted lookup.
module lru_frame_checker
  import lru_pft_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [PAGE_PORT_W-1:0]  page,
  input  logic                    last_ref,
  input  logic                    done,
  input  logic                    hit,
  input  logic [INDEX_PORT_W-1:0] frame_index,
  input  logic                    evicted_valid,
  input  logic [PAGE_PORT_W-1:0]  evicted_page,
  input  logic [COUNT_W-1:0]      fault_count,
  input  logic                    sequence_end,
  output int                      errors,
  output int                      pending,
  output int                      checked,
  output int                      hit_total,
  output int                      evict_total,
  output int                      seq_total,
  output int                      peak_faults
);

  typedef struct packed {
    logic                    hit;
    logic [INDEX_PORT_W-1:0] frame;
    logic                    ev_valid;
    logic [PAGE_PORT_W-1:0]  ev_page;
    count_t                  faults;
    logic                    seq_end;
  } lookup_t;

  // Shadow frame table: pages, occupancy, recency ranks and the fault count.
  page_t  frame_pg  [NUM_FRAMES];
  logic   frame_vld [NUM_FRAMES];
  rank_t  rank_q    [NUM_FRAMES];
  count_t fault_tot;

  lookup_t pending_lookups[$];

  function automatic void clear_frames();
    for (int k = 0; k < NUM_FRAMES; k++) begin
      frame_pg[k]  = '0;
      frame_vld[k] = 1'b0;
      rank_q[k]    = '0;
    end
    fault_tot = '0;
  endfunction

  // Make frame f the most recent one. A newly filled frame ages every other
  // resident frame; a frame that was already resident ages only the frames
  // that were more recent than it.
  function automatic void promote_frame(int f, bit was_valid);
    rank_t old_rank;
    old_rank = rank_q[f];
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (k != f && frame_vld[k] && (!was_valid || rank_q[k] < old_rank))
        rank_q[k] = rank_q[k] + 1'b1;
    end
    rank_q[f] = '0;
  endfunction

  // Look one page up in the shadow table and return the result it must give.
  function automatic lookup_t lookup_page(page_t pg, logic lst);
    lookup_t r;
    int      slot;
    r    = '0;
    slot = -1;
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (slot < 0 && frame_vld[k] && frame_pg[k] == pg)
        slot = k;
    end
    if (slot >= 0) begin
      r.hit = 1'b1;
      promote_frame(slot, 1'b1);
    end else begin
      // Empty frames are filled in index order before anything is evicted.
      for (int k = 0; k < NUM_FRAMES; k++) begin
        if (slot < 0 && !frame_vld[k])
          slot = k;
      end
      if (slot >= 0) begin
        frame_pg[slot]  = pg;
        frame_vld[slot] = 1'b1;
        promote_frame(slot, 1'b0);
      end else begin
        slot = 0;
        for (int k = 1; k < NUM_FRAMES; k++) begin
          if (rank_q[k] > rank_q[slot])
            slot = k;
        end
        r.ev_valid     = 1'b1;
        r.ev_page      = PAGE_PORT_W'(frame_pg[slot]);
        frame_pg[slot] = pg;
        promote_frame(slot, 1'b1);
      end
      if (fault_tot != FAULT_MAX)
        fault_tot = fault_tot + 1'b1;
    end
    r.frame   = INDEX_PORT_W'(slot);
    r.faults  = fault_tot;
    r.seq_end = lst;
    // The last reference reports the updated values, then the table empties.
    if (lst)
      clear_frames();
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      errors++;
    end
  endfunction

  // Predict on every reference transfer, compare on every result strobe.
  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      clear_frames();
      pending_lookups.delete();
      errors      = 0;
      checked     = 0;
      hit_total   = 0;
      evict_total = 0;
      seq_total   = 0;
      peak_faults = 0;
    end else begin
      if (start && !busy)
        pending_lookups.push_back(lookup_page(page_t'(page), last_ref));
      if (done) begin
        if (pending_lookups.size() == 0) begin
          $error("result with no reference outstanding");
          errors++;
        end else begin
          want = pending_lookups.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("frame_index", 32'(want.frame), 32'(frame_index));
          check_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
          check_field("evicted_page", 32'(want.ev_page), 32'(evicted_page));
          check_field("fault_count", 32'(want.faults), 32'(fault_count));
          check_field("sequence_end", 32'(want.seq_end), 32'(sequence_end));
          checked++;
          if (want.hit)
            hit_total++;
          if (want.ev_valid)
            evict_total++;
          if (want.seq_end)
            seq_total++;
          if (int'(want.faults) > peak_faults)
            peak_faults = int'(want.faults);
        end
      end
    end
    pending = pending_lookups.size();
  end

endmodule

// File: dv/lru_page_frame_tracker_test.sv
`timescale 1ns / 1ps

module lru_page_frame_tracker_test;
  import lru_pft_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 850;
  localparam int TAIL_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 12;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [PAGE_PORT_W-1:0]  page = '0;
  logic                    last_ref = 1'b0;
  logic                    done;
  logic                    hit;
  logic [INDEX_PORT_W-1:0] frame_index;
  logic                    evicted_valid;
  logic [PAGE_PORT_W-1:0]  evicted_page;
  logic [COUNT_W-1:0]      fault_count;
  logic                    sequence_end;

  int errors;
  int pending;
  int checked;
  int hit_total;
  int evict_total;
  int seq_total;
  int peak_faults;

  int  items_sent = 0;
  int  cycles = 0;
  bit  idle_on = 1'b0;

  lru_page_frame_tracker u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .page          (page),
    .last_ref      (last_ref),
    .done          (done),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .sequence_end  (sequence_end)
  );

  lru_frame_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .page          (page),
    .last_ref      (last_ref),
    .done          (done),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .sequence_end  (sequence_end),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .hit_total     (hit_total),
    .evict_total   (evict_total),
    .seq_total     (seq_total),
    .peak_faults   (peak_faults)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one reference and hold it until the block takes the transfer.
  task automatic send_ref(input logic [PAGE_PORT_W-1:0] pg, input logic lst);
    start    <= 1'b1;
    page     <= pg;
    last_ref <= lst;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0)
      idle_burst($urandom_range(1, 15));
  endtask

  // A sequence over a small working set, so that hits, fills and evictions
  // all occur. Some pages differ from the first one in a single bit.
  task automatic run_working_set(input bit terminate);
    logic [PAGE_PORT_W-1:0] ws [8];
    int ws_n;
    int len;
    ws_n  = $urandom_range(1, 8);
    len   = $urandom_range(1, 40);
    ws[0] = PAGE_PORT_W'($urandom);
    for (int i = 1; i < 8; i++)
      ws[i] = $urandom_range(0, 1) ? PAGE_PORT_W'($urandom)
                                   : ws[0] ^ (16'h1 << $urandom_range(0, 15));
    for (int i = 0; i < len; i++) begin
      maybe_idle();
      send_ref(ws[$urandom_range(0, ws_n - 1)], terminate && i == len - 1);
    end
  endtask

  // One random chunk of traffic: mostly well-formed sequences, some
  // unterminated ones and noise.
  task automatic random_chunk();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      for (int i = 0; i < 8; i++) begin
        maybe_idle();
        send_ref(PAGE_PORT_W'($urandom), $urandom_range(0, 7) == 0);
      end
    end else begin
      run_working_set(mode != 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: page zero against the empty table, extreme page values,
    // filling every frame, hits that reorder recency, and evictions.
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hABCD, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h0001, 1'b1);
    // A one-reference sequence shows that the table was emptied.
    send_ref(16'hFFFF, 1'b1);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'h8000, 1'b1);
    // Five pages in rotation miss every time; the sequence ends on a miss.
    for (int i = 0; i < 7; i++)
      send_ref(16'hAAA0 + 16'(i % 5), i == 6);

    // Random traffic with idle gaps on the reference side.
    while (items_sent < RANDOM_ITEMS - TAIL_ITEMS) begin
      idle_on = ($urandom_range(0, 2) != 0);
      random_chunk();
    end

    // Closing stretch with references back to back.
    idle_on = 1'b0;
    while (items_sent < RANDOM_ITEMS)
      random_chunk();
    start <= 1'b0;

    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d lookups in %0d closed sequences: %0d hits, %0d evictions.",
             checked, seq_total, hit_total, evict_total);
    $display("Largest fault count seen was %0d; the counter tops out at %0d.",
             peak_faults, FAULT_MAX);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
